// ===== hw/rtl/hsvrgb_pkg.sv =====
// Shared constants and types for the HSV to RGB converter.
package hsvrgb_pkg;

    localparam int HUE_BITS       = 9;
    localparam int WEIGHT_BITS    = 6;   // secondary weight, 0..60
    localparam int DIV_GUARD_BITS = 6;   // 60 < 2^6, headroom for the reciprocal
    localparam int SECTOR_DEG     = 60;
    localparam int NUM_STAGES     = 6;

    localparam logic [HUE_BITS-1:0] HUE_60  = 9'd60;
    localparam logic [HUE_BITS-1:0] HUE_120 = 9'd120;
    localparam logic [HUE_BITS-1:0] HUE_180 = 9'd180;
    localparam logic [HUE_BITS-1:0] HUE_240 = 9'd240;
    localparam logic [HUE_BITS-1:0] HUE_300 = 9'd300;
    localparam logic [HUE_BITS-1:0] HUE_360 = 9'd360;
    localparam logic [HUE_BITS-1:0] HUE_480 = 9'd480;

    typedef logic [2:0] sector_t;

    localparam sector_t SEC_R_TO_Y = 3'd0;
    localparam sector_t SEC_Y_TO_G = 3'd1;
    localparam sector_t SEC_G_TO_C = 3'd2;
    localparam sector_t SEC_C_TO_B = 3'd3;
    localparam sector_t SEC_B_TO_M = 3'd4;
    localparam sector_t SEC_M_TO_R = 3'd5;

endpackage

// ===== hw/rtl/hsvrgb_datapath.sv =====
// Six-stage arithmetic pipeline: chroma, secondary term, sector placement.
module hsvrgb_datapath
    import hsvrgb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
)
(
    input  logic                    clk,
    input  logic [NUM_STAGES-1:0]   en,
    input  logic [HUE_BITS-1:0]     hue,
    input  logic [CHANNEL_BITS-1:0] saturation,
    input  logic [CHANNEL_BITS-1:0] brightness,
    output logic [CHANNEL_BITS-1:0] red,
    output logic [CHANNEL_BITS-1:0] green,
    output logic [CHANNEL_BITS-1:0] blue
);

    localparam int CB    = CHANNEL_BITS;
    localparam int XW    = CB + WEIGHT_BITS;
    localparam int SHIFT = XW + DIV_GUARD_BITS;
    localparam int RW    = XW + 1;
    localparam int PW    = XW + RW;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + longint'(SECTOR_DEG) - 64'd1) / SECTOR_DEG;
    localparam logic [RW-1:0]   RECIP_C = RW'(RECIP);
    localparam logic [2*CB-1:0] FULL    = {{CB{1'b0}}, {CB{1'b1}}};

    // stage 1
    logic [HUE_BITS-1:0]    phase;
    logic [2*CB-1:0]        s1_prod_next,   s1_prod_reg;
    logic [CB-1:0]          s1_val_reg;
    logic [WEIGHT_BITS-1:0] s1_weight_next, s1_weight_reg;
    sector_t                s1_sector_next, s1_sector_reg;
    // stage 2
    logic [2*CB-1:0]        s2_sum;
    logic [CB-1:0]          s2_quot_next, s2_quot_reg;
    logic [2*CB-1:0]        s2_prod_reg;
    logic [CB-1:0]          s2_val_reg;
    logic [WEIGHT_BITS-1:0] s2_weight_reg;
    sector_t                s2_sector_reg;
    // stage 3
    logic [2*CB-1:0]        s3_back, s3_rem;
    logic [CB-1:0]          s3_chroma_next, s3_chroma_reg;
    logic [CB-1:0]          s3_val_reg;
    logic [WEIGHT_BITS-1:0] s3_weight_reg;
    sector_t                s3_sector_reg;
    // stage 4
    logic [XW-1:0]          s4_prod_next, s4_prod_reg;
    logic [CB-1:0]          s4_floor_next, s4_floor_reg;
    logic [CB-1:0]          s4_chroma_reg;
    sector_t                s4_sector_reg;
    // stage 5
    logic [PW-1:0]          s5_prod_next, s5_prod_reg;
    logic [CB-1:0]          s5_floor_reg, s5_chroma_reg;
    sector_t                s5_sector_reg;
    // stage 6
    logic [CB-1:0]          second, base_r, base_g, base_b;
    logic [CB-1:0]          red_next, green_next, blue_next;
    logic [CB-1:0]          red_reg, green_reg, blue_reg;

    // stage 1: value x saturation, hue mod 120 and sector
    always_comb
    begin
        s1_prod_next = (2*CB)'(brightness) * (2*CB)'(saturation);

        if (hue >= HUE_480)
            phase = hue - HUE_480;
        else if (hue >= HUE_360)
            phase = hue - HUE_360;
        else if (hue >= HUE_240)
            phase = hue - HUE_240;
        else if (hue >= HUE_120)
            phase = hue - HUE_120;
        else
            phase = hue;

        // 60 - |phase - 60|
        if (phase < HUE_60)
            s1_weight_next = phase[WEIGHT_BITS-1:0];
        else
            s1_weight_next = WEIGHT_BITS'(HUE_120 - phase);

        if (hue < HUE_60)
            s1_sector_next = SEC_R_TO_Y;
        else if (hue < HUE_120)
            s1_sector_next = SEC_Y_TO_G;
        else if (hue < HUE_180)
            s1_sector_next = SEC_G_TO_C;
        else if (hue < HUE_240)
            s1_sector_next = SEC_C_TO_B;
        else if (hue < HUE_300)
            s1_sector_next = SEC_B_TO_M;
        else
            s1_sector_next = SEC_M_TO_R;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_prod_reg   <= s1_prod_next;
            s1_val_reg    <= brightness;
            s1_weight_reg <= s1_weight_next;
            s1_sector_reg <= s1_sector_next;
        end
    end

    // stage 2: first estimate of prod / (2^CB - 1), low by at most one
    always_comb
    begin
        s2_sum       = s1_prod_reg + (s1_prod_reg >> CB);
        s2_quot_next = s2_sum[2*CB-1:CB];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_quot_reg   <= s2_quot_next;
            s2_prod_reg   <= s1_prod_reg;
            s2_val_reg    <= s1_val_reg;
            s2_weight_reg <= s1_weight_reg;
            s2_sector_reg <= s1_sector_reg;
        end
    end

    // stage 3: remainder check and correction
    always_comb
    begin
        s3_back = {s2_quot_reg, {CB{1'b0}}} - {{CB{1'b0}}, s2_quot_reg};
        s3_rem  = s2_prod_reg - s3_back;
        if (s3_rem >= FULL)
            s3_chroma_next = s2_quot_reg + CB'(1);
        else
            s3_chroma_next = s2_quot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_chroma_reg <= s3_chroma_next;
            s3_val_reg    <= s2_val_reg;
            s3_weight_reg <= s2_weight_reg;
            s3_sector_reg <= s2_sector_reg;
        end
    end

    // stage 4: chroma x weight, floor
    always_comb
    begin
        s4_prod_next  = XW'(s3_chroma_reg) * XW'(s3_weight_reg);
        s4_floor_next = s3_val_reg - s3_chroma_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_prod_reg   <= s4_prod_next;
            s4_floor_reg  <= s4_floor_next;
            s4_chroma_reg <= s3_chroma_reg;
            s4_sector_reg <= s3_sector_reg;
        end
    end

    // stage 5: divide by 60 through the reciprocal, exact for XW-bit operands
    always_comb
    begin
        s5_prod_next = PW'(s4_prod_reg) * PW'(RECIP_C);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_prod_reg   <= s5_prod_next;
            s5_floor_reg  <= s4_floor_reg;
            s5_chroma_reg <= s4_chroma_reg;
            s5_sector_reg <= s4_sector_reg;
        end
    end

    // stage 6: place chroma and secondary term, add floor
    always_comb
    begin
        second = s5_prod_reg[SHIFT +: CB];
        case (s5_sector_reg)
            SEC_R_TO_Y:
            begin
                base_r = s5_chroma_reg; base_g = second;        base_b = '0;
            end
            SEC_Y_TO_G:
            begin
                base_r = second;        base_g = s5_chroma_reg; base_b = '0;
            end
            SEC_G_TO_C:
            begin
                base_r = '0;            base_g = s5_chroma_reg; base_b = second;
            end
            SEC_C_TO_B:
            begin
                base_r = '0;            base_g = second;        base_b = s5_chroma_reg;
            end
            SEC_B_TO_M:
            begin
                base_r = second;        base_g = '0;            base_b = s5_chroma_reg;
            end
            default:
            begin
                base_r = s5_chroma_reg; base_g = '0;            base_b = second;
            end
        endcase
        red_next   = base_r + s5_floor_reg;
        green_next = base_g + s5_floor_reg;
        blue_next  = base_b + s5_floor_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter: stream wrapper and pipeline flow control.
// An accepted input beat passes through the stage registers in order to its output beat.
// Throughput: one pixel per cycle while the output is not stalled; set by the six-stage arithmetic pipeline.
// Each stage holds its beat while the next stage cannot load, so back-pressure loses nothing.
// Reset (rst_n low, asynchronous) empties the pipeline; no other state is kept.
module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // hue[8:0], saturation, brightness; zero padded to bytes
    input  logic [((HUE_BITS+2*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // red, green, blue; zero padded to bytes
    output logic [((3*CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int CB    = CHANNEL_BITS;
    localparam int OUT_W = ((3*CB+7)/8)*8;
    localparam int LAST  = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] valid_next, valid_reg;
    logic [NUM_STAGES-1:0] ready;
    logic [NUM_STAGES-1:0] en;
    logic [CB-1:0]         red, green, blue;

    // a stage may load when it is empty or its beat moves on this cycle
    always_comb
    begin
        ready[LAST] = !valid_reg[LAST] || m_tready;
        for (int i = LAST - 1; i >= 0; i--)
            ready[i] = !valid_reg[i] || ready[i+1];

        valid_next = valid_reg;
        en         = '0;
        if (ready[0])
        begin
            valid_next[0] = s_tvalid;
            en[0]         = s_tvalid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = valid_reg[i-1];
                en[i]         = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    hsvrgb_datapath #(
        .CHANNEL_BITS (CB)
    ) u_datapath (
        .clk        (clk),
        .en         (en),
        .hue        (s_tdata[HUE_BITS-1:0]),
        .saturation (s_tdata[HUE_BITS +: CB]),
        .brightness (s_tdata[HUE_BITS+CB +: CB]),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = OUT_W'({blue, green, red});

`ifndef NO_ASSERTIONS
    // accepted beat lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted beat missing from first stage");

    // full pipeline with a stalled output cannot take a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !m_tready) |-> !s_tready)
        else $error("input ready while pipeline is full and stalled");

    // a blocked first stage keeps its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !ready[0]) |=> valid_reg[0])
        else $error("stalled beat dropped from first stage");

    // occupancy only grows when a beat is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) |=>
            ($countones(valid_reg) <= $past($countones(valid_reg))))
        else $error("beat created inside the pipeline");
`endif

endmodule

// ===== verif/hsv_to_rgb_converter_tb.sv =====
// Testbench for hsv_to_rgb_converter: stream driver, monitor and pixel predictor.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb;
    import hsvrgb_pkg::*;

    localparam int CHANNEL_BITS = 8;
    localparam int FULL_SCALE   = (1 << CHANNEL_BITS) - 1;
    localparam int DIN_W        = ((HUE_BITS + 2*CHANNEL_BITS + 7)/8)*8;
    localparam int DOUT_W       = ((3*CHANNEL_BITS + 7)/8)*8;
    localparam int RANDOM_PIXELS = 1900;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 50;

    typedef struct {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } pixel_t;

    typedef struct {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DIN_W-1:0]  s_tdata;   // hue[8:0], saturation, brightness, zero pad
    logic              m_tvalid;
    logic              m_tready;
    logic [DOUT_W-1:0] m_tdata;   // red, green, blue

    pixel_t pending_pixels[$];
    rgb_t   expected_rgb[$];
    pixel_t cur_pixel;
    int     n_pixels;
    int     accepted_count;
    int     mismatch_count;
    int     cycle_count;
    int     burst_left;
    int     gap_left;
    int     stall_mode;
    int     stall_phase;
    int     stall_left;

    hsv_to_rgb_converter #(.CHANNEL_BITS(CHANNEL_BITS)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Integer HSV to RGB; both divisions truncate, floor added to every channel
    function automatic rgb_t hsv_pixel_to_rgb(pixel_t px);
        int   chroma;
        int   second;
        int   floor_v;
        int   phase;
        int   hue_dist;
        int   r;
        int   g;
        int   b;
        rgb_t res;
        chroma   = (int'(px.brightness) * int'(px.saturation)) / FULL_SCALE;
        phase    = int'(px.hue) % (2*SECTOR_DEG);
        hue_dist = (phase >= SECTOR_DEG) ? phase - SECTOR_DEG : SECTOR_DEG - phase;
        second   = (chroma * (SECTOR_DEG - hue_dist)) / SECTOR_DEG;
        floor_v  = int'(px.brightness) - chroma;
        if (px.hue < HUE_60)
        begin
            r = chroma; g = second; b = 0;
        end
        else if (px.hue < HUE_120)
        begin
            r = second; g = chroma; b = 0;
        end
        else if (px.hue < HUE_180)
        begin
            r = 0; g = chroma; b = second;
        end
        else if (px.hue < HUE_240)
        begin
            r = 0; g = second; b = chroma;
        end
        else if (px.hue < HUE_300)
        begin
            r = second; g = 0; b = chroma;
        end
        else
        begin
            // 300 upwards, including out-of-range hues
            r = chroma; g = 0; b = second;
        end
        res.red   = CHANNEL_BITS'(r + floor_v);
        res.green = CHANNEL_BITS'(g + floor_v);
        res.blue  = CHANNEL_BITS'(b + floor_v);
        return res;
    endfunction

    function automatic int pick_channel();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 0;
        else if (sel == 1)
            return FULL_SCALE;
        else
            return int'($urandom_range(0, FULL_SCALE));
    endfunction

    task automatic add_pixel(int hue, int sat, int val);
        pixel_t px;
        px.hue        = HUE_BITS'(hue);
        px.saturation = CHANNEL_BITS'(sat);
        px.brightness = CHANNEL_BITS'(val);
        pending_pixels.push_back(px);
    endtask

    task automatic check_channel(string name, logic [CHANNEL_BITS-1:0] exp_v,
                                 logic [CHANNEL_BITS-1:0] got_v);
        if (exp_v !== got_v)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        end
    endtask

    // Source side: bursts of beats separated by random gaps
    always @(posedge clk)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                expected_rgb.push_back(hsv_pixel_to_rgb(cur_pixel));
                accepted_count++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_pixels.size() > 0)
                begin
                    cur_pixel  = pending_pixels.pop_front();
                    s_tdata   <= DIN_W'({cur_pixel.brightness, cur_pixel.saturation,
                                         cur_pixel.hue});
                    next_valid = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Sink side: stall pattern is redrawn each time stall_phase wraps to zero
    always @(posedge clk)
    begin
        rgb_t exp_px;
        logic next_ready;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_rgb.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected beat, expected none, got %h", $time, m_tdata);
                end
                else
                begin
                    exp_px = expected_rgb.pop_front();
                    check_channel("red",   exp_px.red,   m_tdata[CHANNEL_BITS-1:0]);
                    check_channel("green", exp_px.green, m_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]);
                    check_channel("blue",  exp_px.blue,
                                  m_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
                end
            end
            if (stall_phase == 0)
                stall_mode = $urandom_range(0, 3);
            stall_phase = (stall_phase + 1) % 64;
            case (stall_mode)
                0: next_ready = 1'b1;
                1: next_ready = 1'($urandom_range(0, 1));
                2: next_ready = (stall_phase % 4) == 3;
                default:
                begin
                    // long stalls between short open windows
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        next_ready = 1'b0;
                    end
                    else
                    begin
                        stall_left = $urandom_range(0, 10);
                        next_ready = 1'b1;
                    end
                end
            endcase
            m_tready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        accepted_count = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        gap_left       = 0;
        stall_mode     = 0;
        stall_phase    = 0;
        stall_left     = 0;

        // sector edges at full scale, then beyond 359
        add_pixel(0, 255, 255);
        add_pixel(59, 255, 255);
        add_pixel(60, 255, 255);
        add_pixel(119, 255, 255);
        add_pixel(120, 255, 255);
        add_pixel(179, 255, 255);
        add_pixel(180, 255, 255);
        add_pixel(239, 255, 255);
        add_pixel(240, 255, 255);
        add_pixel(299, 255, 255);
        add_pixel(300, 255, 255);
        add_pixel(359, 255, 255);
        add_pixel(360, 255, 255);
        add_pixel(450, 200, 100);
        add_pixel(511, 255, 255);
        // grey, black, a mid-range pixel, and tiny chroma
        add_pixel(30, 0, 255);
        add_pixel(30, 255, 0);
        add_pixel(0, 0, 0);
        add_pixel(90, 128, 200);
        add_pixel(330, 1, 1);
        add_pixel(210, 255, 1);
        add_pixel(150, 1, 255);
        for (int i = 0; i < RANDOM_PIXELS; i++)
            add_pixel(($urandom_range(0, 9) == 0) ? $urandom_range(360, 511)
                                                    : $urandom_range(0, 359),
                      pick_channel(), pick_channel());
        n_pixels = pending_pixels.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < n_pixels || expected_rgb.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
